>>> hdl/ataddr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA address unit package
// Widths, command codes, controller states and the controller/datapath
// command and status bundles shared by the address unit modules.
// ----------------------------------------------------------------------------
package ataddr_pkg;

   localparam int SECTOR_W   = 8;
   localparam int CYL_W      = 16;
   localparam int HEAD_W     = 4;
   localparam int LHEADS_W   = HEAD_W + 1;
   localparam int DISK_W     = 28;
   localparam int ADDR_W     = 28;
   localparam int DIVISOR_W  = 12;
   localparam int PARTIAL_W  = CYL_W + LHEADS_W;
   localparam int FULL_W     = PARTIAL_W + SECTOR_W;
   localparam int DIV_CNT_W  = $clog2(DISK_W);

   localparam logic [CYL_W-1:0] CYL_SAT = {CYL_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_LOAD      = 2'd0,
      CMD_ADVANCE   = 2'd1,
      CMD_TRANSLATE = 2'd2,
      CMD_NONE      = 2'd3
   } command_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_SUM  = 6'b010000,
      ST_RESP = 6'b100000
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic div_start;
      logic cyl_load;
      logic mul;
      logic sum;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } ctrl_status_type;

endpackage

>>> hdl/ata_chs_lba_address_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA CHS/LBA address unit
// Task-file position registers with LBA/CHS advance, geometry translation
// and linear block address reporting.
// ----------------------------------------------------------------------------
// The unit holds the current sector, cylinder, head and LBA-mode bit of an
// ATA task file plus a logical CHS geometry. Each item carries a command:
// load the address registers, advance one sector, or set the geometry from
// a head number and a sector count (the cylinder count becomes the disk
// size over heads times sectors, saturated at 65535). Every item returns
// one result: the block address of the new position, or an invalid flag
// when a CHS position lies outside the geometry, plus the registers. One
// item is worked at a time: an item that needs no divide passes through the
// execute, multiply and sum states to its result, and the unit takes the
// next item in the cycle after the result is taken. A geometry command
// with a nonzero count also runs the bit-serial divider between execute
// and multiply, one quotient bit per cycle over the 28-bit disk size.
// The disk size register may be written whenever no item is in flight.
// ----------------------------------------------------------------------------
module ata_chs_lba_address_unit_core (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [ataddr_pkg::DISK_W-1:0]       csr_write_data,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic [ataddr_pkg::SECTOR_W-1:0]     req_sector_in,
   input  logic [ataddr_pkg::CYL_W-1:0]        req_cylinder_in,
   input  logic [ataddr_pkg::HEAD_W-1:0]       req_head_in,
   input  logic                                req_lba_mode_in,
   input  logic [ataddr_pkg::SECTOR_W-1:0]     req_count_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ataddr_pkg::ADDR_W-1:0]       rsp_block_address,
   output logic                                rsp_address_invalid,
   output logic [ataddr_pkg::SECTOR_W-1:0]     rsp_sector_out,
   output logic [ataddr_pkg::CYL_W-1:0]        rsp_cylinder_out,
   output logic [ataddr_pkg::HEAD_W-1:0]       rsp_head_out
);

   ataddr_pkg::ctrl_cmd_type     cmd;
   ataddr_pkg::ctrl_status_type  status;

   // sequence each item through execute, optional divide, and address math
   ataddr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers stay put while the response waits, so they drive the outputs
   ataddr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_sector_in    (req_sector_in),
      .req_cylinder_in  (req_cylinder_in),
      .req_head_in      (req_head_in),
      .req_lba_mode_in  (req_lba_mode_in),
      .req_count_in     (req_count_in),
      .block_address    (rsp_block_address),
      .address_invalid  (rsp_address_invalid),
      .sector_out       (rsp_sector_out),
      .cylinder_out     (rsp_cylinder_out),
      .head_out         (rsp_head_out)
   );

endmodule

>>> hdl/ataddr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA address unit divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ataddr_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ataddr_pkg::DISK_W-1:0]       dividend,
   input  logic [ataddr_pkg::DIVISOR_W-1:0]    divisor,
   output logic [ataddr_pkg::DISK_W-1:0]       quotient,
   output logic                                done
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [ataddr_pkg::DIVISOR_W-1:0]      rem_ff, rem_in;
   logic [ataddr_pkg::DISK_W-1:0]         quo_ff, quo_in;
   logic [ataddr_pkg::DIVISOR_W-1:0]      dsr_ff, dsr_in;
   logic [ataddr_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ataddr_pkg::DIVISOR_W:0]        shifted;
   logic [ataddr_pkg::DIVISOR_W:0]        diff;
   logic                                  fits;

   assign shifted = {rem_ff, quo_ff[ataddr_pkg::DISK_W-1]};
   assign fits    = shifted >= {1'b0, dsr_ff};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = ataddr_pkg::DIV_CNT_W'(ataddr_pkg::DISK_W - 1);
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         rem_in = fits ? diff[ataddr_pkg::DIVISOR_W-1:0]
                       : shifted[ataddr_pkg::DIVISOR_W-1:0];
         quo_in = {quo_ff[ataddr_pkg::DISK_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

>>> hdl/ataddr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA address unit datapath
// Task-file position, translation geometry, divider and address arithmetic.
// ----------------------------------------------------------------------------
module ataddr_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  ataddr_pkg::ctrl_cmd_type            cmd,
   output ataddr_pkg::ctrl_status_type         status,
   input  logic                                csr_write_enable,
   input  logic [ataddr_pkg::DISK_W-1:0]       csr_write_data,
   input  logic [1:0]                          req_command,
   input  logic [ataddr_pkg::SECTOR_W-1:0]     req_sector_in,
   input  logic [ataddr_pkg::CYL_W-1:0]        req_cylinder_in,
   input  logic [ataddr_pkg::HEAD_W-1:0]       req_head_in,
   input  logic                                req_lba_mode_in,
   input  logic [ataddr_pkg::SECTOR_W-1:0]     req_count_in,
   output logic [ataddr_pkg::ADDR_W-1:0]       block_address,
   output logic                                address_invalid,
   output logic [ataddr_pkg::SECTOR_W-1:0]     sector_out,
   output logic [ataddr_pkg::CYL_W-1:0]        cylinder_out,
   output logic [ataddr_pkg::HEAD_W-1:0]       head_out
);

   // captured item
   ataddr_pkg::command_type               cmd_ff;
   logic [ataddr_pkg::SECTOR_W-1:0]       sector_q_ff;
   logic [ataddr_pkg::CYL_W-1:0]          cyl_q_ff;
   logic [ataddr_pkg::HEAD_W-1:0]         head_q_ff;
   logic                                  lba_q_ff;
   logic [ataddr_pkg::SECTOR_W-1:0]       count_q_ff;

   // architectural state
   logic [ataddr_pkg::DISK_W-1:0]         disk_ff;
   logic [ataddr_pkg::SECTOR_W-1:0]       sector_ff, sector_in;
   logic [ataddr_pkg::CYL_W-1:0]          cyl_ff, cyl_in;
   logic [ataddr_pkg::HEAD_W-1:0]         head_ff, head_in;
   logic                                  lba_ff, lba_in;
   logic [ataddr_pkg::LHEADS_W-1:0]       lheads_ff, lheads_in;
   logic [ataddr_pkg::SECTOR_W-1:0]       lsecs_ff, lsecs_in;
   logic [ataddr_pkg::CYL_W-1:0]          lcyls_ff, lcyls_in;

   // arithmetic
   logic [ataddr_pkg::PARTIAL_W-1:0]      partial_ff;
   logic [ataddr_pkg::ADDR_W-1:0]         block_ff, block_in;
   logic                                  bad_ff;

   logic [ataddr_pkg::ADDR_W-1:0]         lba_addr;
   logic [ataddr_pkg::ADDR_W-1:0]         lba_next;
   logic [ataddr_pkg::LHEADS_W-1:0]       heads_new;
   logic [ataddr_pkg::LHEADS_W+ataddr_pkg::SECTOR_W-1:0] div_prod;
   logic [ataddr_pkg::DISK_W-1:0]         quotient;
   logic                                  div_done;
   logic [ataddr_pkg::CYL_W-1:0]          cyl_sat;
   logic [ataddr_pkg::FULL_W-1:0]         chs_full;
   logic                                  bad;

   assign lba_addr  = {head_ff, cyl_ff, sector_ff};
   assign lba_next  = lba_addr + 1'b1;
   assign heads_new = ataddr_pkg::LHEADS_W'(head_q_ff) + ataddr_pkg::LHEADS_W'(1);
   assign div_prod  = heads_new * count_q_ff;

   assign status.need_div = (cmd_ff == ataddr_pkg::CMD_TRANSLATE) && (count_q_ff != '0);
   assign status.div_done = div_done;

   ataddr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (disk_ff),
      .divisor  (ataddr_pkg::DIVISOR_W'(div_prod)),
      .quotient (quotient),
      .done     (div_done)
   );

   assign cyl_sat = (quotient >= ataddr_pkg::DISK_W'(ataddr_pkg::CYL_SAT))
                    ? ataddr_pkg::CYL_SAT : quotient[ataddr_pkg::CYL_W-1:0];

   // next state of the task-file registers and geometry
   always_comb begin
      sector_in = sector_ff;
      cyl_in    = cyl_ff;
      head_in   = head_ff;
      lba_in    = lba_ff;
      lheads_in = lheads_ff;
      lsecs_in  = lsecs_ff;
      lcyls_in  = lcyls_ff;
      if (cmd.execute) begin
         unique case (cmd_ff)
            ataddr_pkg::CMD_LOAD: begin
               sector_in = sector_q_ff;
               cyl_in    = cyl_q_ff;
               head_in   = head_q_ff;
               lba_in    = lba_q_ff;
            end
            ataddr_pkg::CMD_ADVANCE: begin
               if (lba_ff) begin
                  {head_in, cyl_in, sector_in} = lba_next;
               end else if (sector_ff == lsecs_ff) begin
                  sector_in = ataddr_pkg::SECTOR_W'(1);
                  if (ataddr_pkg::LHEADS_W'(head_ff) == lheads_ff - 1'b1) begin
                     head_in = '0;
                     cyl_in  = (cyl_ff == lcyls_ff - 1'b1) ? '0 : cyl_ff + 1'b1;
                  end else begin
                     head_in = head_ff + 1'b1;
                  end
               end else begin
                  sector_in = sector_ff + 1'b1;
               end
            end
            ataddr_pkg::CMD_TRANSLATE: begin
               lheads_in = heads_new;
               lsecs_in  = count_q_ff;
            end
            default: begin
            end
         endcase
      end
      if (cmd.cyl_load) begin
         lcyls_in = cyl_sat;
      end
   end

   assign bad = !lba_ff &&
                ((sector_ff == '0) || (sector_ff > lsecs_ff) || (cyl_ff >= lcyls_ff) ||
                 (ataddr_pkg::LHEADS_W'(head_ff) >= lheads_ff));

   assign chs_full = ataddr_pkg::FULL_W'(partial_ff) * ataddr_pkg::FULL_W'(lsecs_ff)
                     + ataddr_pkg::FULL_W'(sector_ff) - ataddr_pkg::FULL_W'(1);

   always_comb begin
      if (lba_ff) begin
         block_in = lba_addr;
      end else if (bad) begin
         block_in = '0;
      end else begin
         block_in = chs_full[ataddr_pkg::ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_ff   <= '0;
         sector_ff <= ataddr_pkg::SECTOR_W'(1);
         cyl_ff    <= '0;
         head_ff   <= '0;
         lba_ff    <= 1'b0;
         lheads_ff <= '0;
         lsecs_ff  <= '0;
         lcyls_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            disk_ff <= csr_write_data;
         end
         sector_ff <= sector_in;
         cyl_ff    <= cyl_in;
         head_ff   <= head_in;
         lba_ff    <= lba_in;
         lheads_ff <= lheads_in;
         lsecs_ff  <= lsecs_in;
         lcyls_ff  <= lcyls_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff      <= ataddr_pkg::command_type'(req_command);
         sector_q_ff <= req_sector_in;
         cyl_q_ff    <= req_cylinder_in;
         head_q_ff   <= req_head_in;
         lba_q_ff    <= req_lba_mode_in;
         count_q_ff  <= req_count_in;
      end
      if (cmd.mul) begin
         partial_ff <= ataddr_pkg::PARTIAL_W'(cyl_ff) * ataddr_pkg::PARTIAL_W'(lheads_ff)
                       + ataddr_pkg::PARTIAL_W'(head_ff);
      end
      if (cmd.sum) begin
         block_ff <= block_in;
         bad_ff   <= bad;
      end
   end

   assign block_address   = block_ff;
   assign address_invalid = bad_ff;
   assign sector_out      = sector_ff;
   assign cylinder_out    = cyl_ff;
   assign head_out        = head_ff;

endmodule

>>> hdl/ataddr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA address unit controller
// Sequences capture, execute, divide, multiply, sum and response for one item.
// ----------------------------------------------------------------------------
module ataddr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  ataddr_pkg::ctrl_status_type   status,
   output ataddr_pkg::ctrl_cmd_type      cmd
);

   ataddr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ataddr_pkg::ST_IDLE: if (req_valid) state_in = ataddr_pkg::ST_EXEC;
         ataddr_pkg::ST_EXEC: state_in = status.need_div ? ataddr_pkg::ST_DIV
                                                         : ataddr_pkg::ST_MUL;
         ataddr_pkg::ST_DIV:  if (status.div_done) state_in = ataddr_pkg::ST_MUL;
         ataddr_pkg::ST_MUL:  state_in = ataddr_pkg::ST_SUM;
         ataddr_pkg::ST_SUM:  state_in = ataddr_pkg::ST_RESP;
         ataddr_pkg::ST_RESP: if (rsp_ready) state_in = ataddr_pkg::ST_IDLE;
         default:             state_in = ataddr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ataddr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready     = (state_ff == ataddr_pkg::ST_IDLE);
   assign rsp_valid     = (state_ff == ataddr_pkg::ST_RESP);
   assign cmd.capture   = req_ready && req_valid;
   assign cmd.execute   = (state_ff == ataddr_pkg::ST_EXEC);
   assign cmd.div_start = (state_ff == ataddr_pkg::ST_EXEC) && status.need_div;
   assign cmd.cyl_load  = (state_ff == ataddr_pkg::ST_DIV) && status.div_done;
   assign cmd.mul       = (state_ff == ataddr_pkg::ST_MUL);
   assign cmd.sum       = (state_ff == ataddr_pkg::ST_SUM);

endmodule
